FILE: hdl/rgb_pixel_blend_unit_assert.svh
// Assertion macros used by the checker file of the blend unit.
`ifndef RGB_PIXEL_BLEND_UNIT_ASSERT_SVH
`define RGB_PIXEL_BLEND_UNIT_ASSERT_SVH

// Clocked assertion, switched off while reset is asserted.
`define RPB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define RPB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/rpb_pkg.sv
package rpb_pkg;

    // Pixel channel width
    localparam int PIX_W = 8;

    // Blend mode codes
    localparam logic [2:0] MODE_MULTIPLY = 3'd0;
    localparam logic [2:0] MODE_SCREEN   = 3'd1;
    localparam logic [2:0] MODE_OVERLAY  = 3'd2;
    localparam logic [2:0] MODE_SUBTRACT = 3'd3;
    localparam logic [2:0] MODE_ADD      = 3'd4;
    localparam logic [2:0] MODE_SCALE    = 3'd5;

    // Channel codes
    localparam logic [1:0] CH_BLUE  = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_RED   = 2'd2;

    // Register indexes (byte address divided by four)
    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_CHANNEL = 2'd1;
    localparam logic [1:0] REG_ADD     = 2'd2;
    localparam logic [1:0] REG_SCALE   = 2'd3;

    localparam int          ADDR_W      = 4;
    localparam logic [15:0] SCALE_RESET = 16'd256;

    // How the last stage forms a channel result
    localparam logic [1:0] KIND_DIRECT = 2'd0;
    localparam logic [1:0] KIND_Q      = 2'd1;
    localparam logic [1:0] KIND_INV_Q  = 2'd2;
    localparam logic [1:0] KIND_SCALE  = 2'd3;

    typedef struct packed {
        logic [2:0]  blend_mode;
        logic [1:0]  channel_select;
        logic [8:0]  add_amount;
        logic [15:0] scale_factor;
    } rpb_cfg_t;

    // Load enables of the four pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } rpb_stage_en_t;

endpackage

FILE: hdl/rpb_cfg_regs.sv
module rpb_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rpb_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output rpb_pkg::rpb_cfg_t           cfg
);

    rpb_pkg::rpb_cfg_t cfg_reg;
    rpb_pkg::rpb_cfg_t cfg_next;
    logic              wr_en;
    logic [1:0]        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    // Decode a write into the addressed register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                rpb_pkg::REG_MODE:    cfg_next.blend_mode     = pwdata[2:0];
                rpb_pkg::REG_CHANNEL: cfg_next.channel_select = pwdata[1:0];
                rpb_pkg::REG_ADD:     cfg_next.add_amount     = pwdata[8:0];
                rpb_pkg::REG_SCALE:   cfg_next.scale_factor   = pwdata[15:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blend_mode     <= rpb_pkg::MODE_MULTIPLY;
            cfg_reg.channel_select <= rpb_pkg::CH_BLUE;
            cfg_reg.add_amount     <= 9'd0;
            cfg_reg.scale_factor   <= rpb_pkg::SCALE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (reg_idx)
            rpb_pkg::REG_MODE:    prdata = {29'd0, cfg_reg.blend_mode};
            rpb_pkg::REG_CHANNEL: prdata = {30'd0, cfg_reg.channel_select};
            rpb_pkg::REG_ADD:     prdata = {23'd0, cfg_reg.add_amount};
            rpb_pkg::REG_SCALE:   prdata = {16'd0, cfg_reg.scale_factor};
        endcase
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/rpb_channel.sv
module rpb_channel (
    input  logic                        clk,
    input  rpb_pkg::rpb_stage_en_t      en,
    input  rpb_pkg::rpb_cfg_t           cfg,
    input  logic [1:0]                  ch_id,
    input  logic [rpb_pkg::PIX_W-1:0]   top,
    input  logic [rpb_pkg::PIX_W-1:0]   bottom,
    output logic [rpb_pkg::PIX_W-1:0]   result
);

    // Stage 1: operands
    logic [7:0]  s1_a_reg,      s1_a_next;
    logic [15:0] s1_m_reg,      s1_m_next;
    logic        s1_dbl_reg,    s1_dbl_next;
    logic [1:0]  s1_kind_reg,   s1_kind_next;
    logic [7:0]  s1_direct_reg, s1_direct_next;

    // Stage 2: product
    logic [23:0] s2_prod_reg,   s2_prod_next;
    logic [1:0]  s2_kind_reg;
    logic [7:0]  s2_direct_reg;

    // Stage 3: quotient estimate and scaled value
    logic [17:0] s3_n_reg,      s3_n_next;
    logic [8:0]  s3_qe_reg,     s3_qe_next;
    logic [15:0] s3_sc_reg,     s3_sc_next;
    logic [1:0]  s3_kind_reg;
    logic [7:0]  s3_direct_reg;

    // Stage 4: channel result
    logic [7:0]  res_reg,       res_next;

    logic        sel;
    logic [7:0]  inv_t;
    logic [7:0]  inv_b;
    logic signed [9:0] add_sum;
    logic [23:0] prod;
    logic [25:0] n_x257;
    logic [23:0] sc_sum;
    logic [17:0] qe_x255;
    logic [17:0] rem;
    logic [8:0]  q;

    assign sel     = (cfg.channel_select == ch_id);
    assign inv_t   = 8'd255 - top;
    assign inv_b   = 8'd255 - bottom;
    assign add_sum = $signed({2'b00, top}) + $signed({cfg.add_amount[8], cfg.add_amount});

    // Pick multiplier operands and the way the result is formed
    always_comb
    begin
        s1_a_next      = top;
        s1_m_next      = {8'd0, bottom};
        s1_dbl_next    = 1'b0;
        s1_kind_next   = rpb_pkg::KIND_DIRECT;
        s1_direct_next = top;
        unique case (cfg.blend_mode)
            rpb_pkg::MODE_MULTIPLY:
            begin
                s1_kind_next = rpb_pkg::KIND_Q;
            end
            rpb_pkg::MODE_SCREEN:
            begin
                s1_a_next    = inv_t;
                s1_m_next    = {8'd0, inv_b};
                s1_kind_next = rpb_pkg::KIND_INV_Q;
            end
            rpb_pkg::MODE_OVERLAY:
            begin
                s1_dbl_next = 1'b1;
                if (!bottom[7])
                begin
                    s1_kind_next = rpb_pkg::KIND_Q;
                end
                else
                begin
                    s1_a_next    = inv_t;
                    s1_m_next    = {8'd0, inv_b};
                    s1_kind_next = rpb_pkg::KIND_INV_Q;
                end
            end
            rpb_pkg::MODE_SUBTRACT:
            begin
                s1_direct_next = (bottom >= top) ? (bottom - top) : 8'd0;
            end
            rpb_pkg::MODE_ADD:
            begin
                if (sel)
                begin
                    if (add_sum[9])
                        s1_direct_next = 8'd0;
                    else if (add_sum[8])
                        s1_direct_next = 8'd255;
                    else
                        s1_direct_next = add_sum[7:0];
                end
            end
            rpb_pkg::MODE_SCALE:
            begin
                if (sel)
                begin
                    s1_m_next    = cfg.scale_factor;
                    s1_kind_next = rpb_pkg::KIND_SCALE;
                end
            end
            default:
            begin
                s1_kind_next = rpb_pkg::KIND_DIRECT;
            end
        endcase
    end

    // Multiply, doubling for overlay
    assign prod         = s1_a_reg * s1_m_reg;
    assign s2_prod_next = s1_dbl_reg ? {prod[22:0], 1'b0} : prod;

    // Rounded quotient estimate by 255 and rounded Q8.8 scale
    assign s3_n_next  = s2_prod_reg[17:0] + 18'd127;
    assign n_x257     = {s3_n_next, 8'd0} + {8'd0, s3_n_next};
    assign s3_qe_next = n_x257[24:16];
    assign sc_sum     = s2_prod_reg + 24'd128;
    assign s3_sc_next = sc_sum[23:8];

    // Correct the estimate by one and form the result
    assign qe_x255 = {1'b0, s3_qe_reg, 8'd0} - {9'd0, s3_qe_reg};
    assign rem     = s3_n_reg - qe_x255;
    assign q       = s3_qe_reg + {8'd0, (rem >= 18'd255)};

    always_comb
    begin
        unique case (s3_kind_reg)
            rpb_pkg::KIND_DIRECT: res_next = s3_direct_reg;
            rpb_pkg::KIND_Q:      res_next = q[7:0];
            rpb_pkg::KIND_INV_Q:  res_next = 8'd255 - q[7:0];
            rpb_pkg::KIND_SCALE:  res_next = (|s3_sc_reg[15:8]) ? 8'd255 : s3_sc_reg[7:0];
        endcase
    end

    // Advance each stage on its load enable
    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            s1_a_reg      <= s1_a_next;
            s1_m_reg      <= s1_m_next;
            s1_dbl_reg    <= s1_dbl_next;
            s1_kind_reg   <= s1_kind_next;
            s1_direct_reg <= s1_direct_next;
        end
        if (en.s2)
        begin
            s2_prod_reg   <= s2_prod_next;
            s2_kind_reg   <= s1_kind_reg;
            s2_direct_reg <= s1_direct_reg;
        end
        if (en.s3)
        begin
            s3_n_reg      <= s3_n_next;
            s3_qe_reg     <= s3_qe_next;
            s3_sc_reg     <= s3_sc_next;
            s3_kind_reg   <= s2_kind_reg;
            s3_direct_reg <= s2_direct_reg;
        end
        if (en.s4)
        begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

endmodule

FILE: hdl/rgb_pixel_blend_unit.sv
// Blend unit for 8-bit BGR pixels.
// Input stream s_axis_*: one item carries a top and a bottom pixel; output
// stream m_axis_*: one blended pixel per input item, in order.
// The APB port sets blend mode, channel select, add amount and scale factor
// at byte addresses 0, 4, 8 and 12; write it only while no item is in flight.
// The datapath is a four-stage pipeline per channel: operand select, multiply,
// divide-by-255 estimate, correction and result select. m_axis_tvalid rises
// once an accepted item has passed the operand, product and estimate registers
// into the output register; throughput is one item per cycle while not stalled.
// The final stage is the output register.
// Each stage holds its item while the next stage is full and stalled, so a
// stall on m_axis_tready fills empty stages first and then drops
// s_axis_tready; no item is lost or repeated.
// Reset clears the stage valid bits and sets the registers to multiply mode,
// blue channel, add amount zero and scale factor 1.0.
module rgb_pixel_blend_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // top_blue, top_green, top_red, bottom_blue, bottom_green, bottom_red
    input  logic [47:0]                 s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // out_blue, out_green, out_red
    output logic [23:0]                 m_axis_tdata,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rpb_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    rpb_pkg::rpb_cfg_t      cfg;
    rpb_pkg::rpb_stage_en_t en;
    logic [3:0]             vld_reg;
    logic [3:0]             vld_next;

    rpb_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Load a stage when it is empty or its item moves on
    assign en.s4 = !vld_reg[3] || m_axis_tready;
    assign en.s3 = !vld_reg[2] || en.s4;
    assign en.s2 = !vld_reg[1] || en.s3;
    assign en.s1 = !vld_reg[0] || en.s2;

    assign vld_next[0] = en.s1 ? s_axis_tvalid : vld_reg[0];
    assign vld_next[1] = en.s2 ? vld_reg[0]    : vld_reg[1];
    assign vld_next[2] = en.s3 ? vld_reg[1]    : vld_reg[2];
    assign vld_next[3] = en.s4 ? vld_reg[2]    : vld_reg[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 4'd0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_axis_tready = en.s1;
    assign m_axis_tvalid = vld_reg[3];

    // One datapath per color channel
    for (genvar g = 0; g < 3; g++)
    begin : g_ch
        rpb_channel u_ch (
            .clk    (clk),
            .en     (en),
            .cfg    (cfg),
            .ch_id  (2'(g)),
            .top    (s_axis_tdata[8*g +: 8]),
            .bottom (s_axis_tdata[24 + 8*g +: 8]),
            .result (m_axis_tdata[8*g +: 8])
        );
    end

endmodule

FILE: hdl/rpb_checker.sv
`include "rgb_pixel_blend_unit_assert.svh"

module rpb_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tready,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [23:0]                 m_axis_tdata,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rpb_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    input  logic [31:0]                 prdata,
    input  logic                        pready
);

    // Hold a stalled result
    `RPB_ASSERT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled output item changed")

    // An empty output stage means the whole pipeline can take an item
    `RPB_ASSERT(a_ready_when_empty, clk, rst_n, !m_axis_tvalid |-> s_axis_tready, "input stalled while output stage empty")

    // Read back a scale factor write at the same address
    `RPB_ASSERT(a_scale_readback, clk, rst_n, psel && penable && pwrite && pready && paddr[3:2] == rpb_pkg::REG_SCALE |=> paddr != $past(paddr) || prdata[15:0] == $past(pwdata[15:0]), "scale factor readback mismatch")

    // The configuration port never waits
    `RPB_ASSERT(a_pready_high, clk, rst_n, pready, "pready low")

    // No result right after reset
    `RPB_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !m_axis_tvalid, "output valid right after reset")

endmodule

bind rgb_pixel_blend_unit rpb_checker u_rpb_checker (.*);

FILE: test/tb_top.sv
module tb_top;
    import rpb_pkg::*;

    // Codes outside the defined set: pass-through behavior
    localparam logic [2:0] MODE_UNDEF_LO = 3'd6;
    localparam logic [2:0] MODE_UNDEF_HI = 3'd7;
    localparam logic [1:0] CH_NONE       = 2'd3;

    localparam int RUN_LIMIT     = 2_000_000;
    localparam int PIPE_LATENCY  = 4;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 70;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    // top_blue, top_green, top_red, bottom_blue, bottom_green, bottom_red
    logic [47:0]         s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    // out_blue, out_green, out_red
    logic [23:0]         m_axis_tdata;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // One directed row: register setting, both pixels as {red, green, blue}
    typedef struct {
        rpb_cfg_t    cfg;
        logic [23:0] top;
        logic [23:0] bottom;
        bit          known;
        logic [23:0] result;
    } blend_row_t;

    blend_row_t  plan[$];
    logic [23:0] pixel_expect[$];
    rpb_cfg_t    cfg_shadow;
    int          errors;
    int          burst_left;
    bit          vld_drv;

    rgb_pixel_blend_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Generate the clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Compute one blended channel; idx 0 blue, 1 green, 2 red
    function automatic logic [7:0] blend_channel(rpb_cfg_t c, int idx, int t, int b);
        int prod;
        int amt;
        int r;
        r = t;
        prod = (255 - t) * (255 - b);
        case (c.blend_mode)
            MODE_MULTIPLY: r = (2 * t * b + 255) / 510;
            MODE_SCREEN:   r = 255 - (2 * prod + 255) / 510;
            MODE_OVERLAY:  r = (b <= 127) ? (4 * t * b + 255) / 510
                                          : 255 - (4 * prod + 255) / 510;
            MODE_SUBTRACT: r = (b >= t) ? b - t : 0;
            MODE_ADD:
            begin
                if (idx == c.channel_select)
                begin
                    amt = $signed(c.add_amount);
                    r = t + amt;
                    if (r < 0)
                        r = 0;
                    if (r > 255)
                        r = 255;
                end
            end
            MODE_SCALE:
            begin
                if (idx == c.channel_select)
                begin
                    r = (t * int'(c.scale_factor) + 128) >>> 8;
                    if (r > 255)
                        r = 255;
                end
            end
            default: r = t;
        endcase
        return r[7:0];
    endfunction

    function automatic logic [23:0] blend_pixel(rpb_cfg_t c, logic [23:0] top,
                                                logic [23:0] bottom);
        return {blend_channel(c, 2, top[23:16], bottom[23:16]),
                blend_channel(c, 1, top[15:8],  bottom[15:8]),
                blend_channel(c, 0, top[7:0],   bottom[7:0])};
    endfunction

    // Pick a channel value, leaning on the edges and the overlay threshold
    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h7F;
            3:       return 8'h80;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [23:0] rand_pixel();
        return {rand_chan(), rand_chan(), rand_chan()};
    endfunction

    function automatic rpb_cfg_t rand_cfg();
        rpb_cfg_t c;
        c.blend_mode = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 5))
                                                  : 3'($urandom_range(6, 7));
        c.channel_select = ($urandom_range(0, 7) == 0) ? CH_NONE
                                                       : 2'($urandom_range(0, 2));
        c.add_amount = 9'($urandom_range(0, 511));
        case ($urandom_range(0, 4))
            0:       c.scale_factor = 16'h0000;
            1:       c.scale_factor = 16'hFFFF;
            2:       c.scale_factor = 16'($urandom_range(0, 511));
            default: c.scale_factor = 16'($urandom());
        endcase
        return c;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    task automatic add_row(logic [2:0] mode, logic [1:0] ch, logic [8:0] amt,
                           logic [15:0] factor, logic [23:0] top, logic [23:0] bottom,
                           bit known, logic [23:0] result);
        blend_row_t row;
        row.cfg = '{mode, ch, amt, factor};
        row.top = top;
        row.bottom = bottom;
        row.known = known;
        row.result = result;
        plan.insert(plan.size(), row);
    endtask

    // Change tvalid only when it differs, so one step sees one assignment
    task automatic set_valid(bit v);
        if (v != vld_drv)
        begin
            s_axis_tvalid <= v;
            vld_drv = v;
        end
    endtask

    // Offer one item and hold it until accepted; call at a falling edge
    task automatic send_pixel(logic [23:0] top, logic [23:0] bottom, bit known,
                              logic [23:0] result);
        set_valid(1'b1);
        s_axis_tdata <= {bottom, top};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pixel_expect.insert(pixel_expect.size(),
                            known ? result : blend_pixel(cfg_shadow, top, bottom));
        @(negedge clk);
    endtask

    // Pace the sender: bursts of random length, random gaps between them
    task automatic between_items();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                set_valid(1'b0);
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_MODE:    cfg_shadow.blend_mode     = value[2:0];
            REG_CHANNEL: cfg_shadow.channel_select = value[1:0];
            REG_ADD:     cfg_shadow.add_amount     = value[8:0];
            REG_SCALE:   cfg_shadow.scale_factor   = value[15:0];
            default:     ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Drain the pipeline, then write all four registers with junk upper bits
    task automatic apply_cfg(rpb_cfg_t c);
        logic [31:0] junk;
        set_valid(1'b0);
        while (pixel_expect.size() != 0)
            @(negedge clk);
        junk = $urandom();
        apb_write(REG_MODE,    {junk[31:3], c.blend_mode});
        junk = $urandom();
        apb_write(REG_CHANNEL, {junk[31:2], c.channel_select});
        junk = $urandom();
        apb_write(REG_ADD,     {junk[31:9], c.add_amount});
        junk = $urandom();
        apb_write(REG_SCALE,   {junk[31:16], c.scale_factor});
    endtask

    // Main stimulus: reset, directed rows, then random phases
    initial
    begin : stimulus
        rpb_cfg_t c;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        vld_drv       = 1'b0;
        errors        = 0;
        burst_left    = 0;
        cfg_shadow    = '{MODE_MULTIPLY, CH_BLUE, 9'd0, SCALE_RESET};

        // Directed rows; the first ones run on the reset setting
        add_row(MODE_MULTIPLY, CH_BLUE, 9'd0, SCALE_RESET,
                24'hFFFFFF, 24'hFFFFFF, 1, 24'hFFFFFF);
        add_row(MODE_MULTIPLY, CH_BLUE, 9'd0, SCALE_RESET,
                24'hFFFFFF, 24'h000000, 1, 24'h000000);
        add_row(MODE_MULTIPLY, CH_BLUE, 9'd0, SCALE_RESET,
                24'h80FF01, 24'h7F80FE, 0, '0);
        add_row(MODE_SCREEN, CH_BLUE, 9'd0, SCALE_RESET,
                24'h000000, 24'h000000, 1, 24'h000000);
        add_row(MODE_SCREEN, CH_BLUE, 9'd0, SCALE_RESET,
                24'hFFFFFF, 24'h123456, 1, 24'hFFFFFF);
        add_row(MODE_SCREEN, CH_BLUE, 9'd0, SCALE_RESET,
                24'h40A010, 24'h9033C7, 0, '0);
        // Overlay on both sides of the bottom threshold
        add_row(MODE_OVERLAY, CH_BLUE, 9'd0, SCALE_RESET,
                24'hFFFFFF, 24'h7F7F7F, 0, '0);
        add_row(MODE_OVERLAY, CH_BLUE, 9'd0, SCALE_RESET,
                24'h808080, 24'h808080, 0, '0);
        add_row(MODE_OVERLAY, CH_BLUE, 9'd0, SCALE_RESET,
                24'h000000, 24'hFFFFFF, 1, 24'hFFFFFF);
        add_row(MODE_SUBTRACT, CH_BLUE, 9'd0, SCALE_RESET,
                24'hFFFFFF, 24'h000000, 1, 24'h000000);
        add_row(MODE_SUBTRACT, CH_BLUE, 9'd0, SCALE_RESET,
                24'h102030, 24'hFF2010, 0, '0);
        // Add mode: saturation at both ends, the most negative amount
        add_row(MODE_ADD, CH_RED, 9'd255, SCALE_RESET,
                24'h000180, 24'hFFFFFF, 1, 24'hFF0180);
        add_row(MODE_ADD, CH_GREEN, 9'h101, SCALE_RESET,
                24'hFFFFFF, 24'h000000, 1, 24'hFF00FF);
        add_row(MODE_ADD, CH_BLUE, 9'h100, SCALE_RESET,
                24'h3C3C3C, 24'hA5A5A5, 1, 24'h3C3C00);
        add_row(MODE_ADD, CH_BLUE, 9'h1FF, SCALE_RESET,
                24'h7F8000, 24'h5A5A5A, 0, '0);
        add_row(MODE_ADD, CH_NONE, 9'd100, SCALE_RESET,
                24'h123456, 24'hFFFFFF, 1, 24'h123456);
        // Scale mode: zero, saturation, rounding tie, no channel
        add_row(MODE_SCALE, CH_RED, 9'd0, 16'h0000,
                24'hFFFFFF, 24'h000000, 1, 24'h00FFFF);
        add_row(MODE_SCALE, CH_BLUE, 9'd0, 16'hFFFF,
                24'h010101, 24'h000000, 1, 24'h0101FF);
        add_row(MODE_SCALE, CH_GREEN, 9'd0, 16'h0080,
                24'h000100, 24'h000000, 0, '0);
        add_row(MODE_SCALE, CH_GREEN, 9'd0, 16'h0180,
                24'h00FF03, 24'hFFFFFF, 0, '0);
        add_row(MODE_SCALE, CH_NONE, 9'd0, 16'hFFFF,
                24'hABCDEF, 24'h000000, 1, 24'hABCDEF);
        // Undefined modes pass the top pixel through
        add_row(MODE_UNDEF_LO, CH_BLUE, 9'd0, SCALE_RESET,
                24'h5A5A5A, 24'h000000, 1, 24'h5A5A5A);
        add_row(MODE_UNDEF_HI, CH_RED, 9'd255, 16'hFFFF,
                24'hA5C3E1, 24'hFFFFFF, 1, 24'hA5C3E1);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].cfg != cfg_shadow)
                apply_cfg(plan[i].cfg);
            send_pixel(plan[i].top, plan[i].bottom, plan[i].known, plan[i].result);
            between_items();
        end

        // Random phases, the first few on extreme settings
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       c = '{MODE_SCALE, CH_RED,   9'd0,   16'hFFFF};
                1:       c = '{MODE_SCALE, CH_GREEN, 9'd0,   16'h0000};
                2:       c = '{MODE_ADD,   CH_BLUE,  9'h100, SCALE_RESET};
                3:       c = '{MODE_ADD,   CH_RED,   9'd255, SCALE_RESET};
                default: c = rand_cfg();
            endcase
            apply_cfg(c);
            repeat (PHASE_ITEMS)
            begin
                send_pixel(rand_pixel(), rand_pixel(), 0, '0);
                between_items();
            end
        end

        // Wait out every result, then idle before reporting the verdict
        set_valid(1'b0);
        while (pixel_expect.size() != 0)
            @(negedge clk);
        repeat (2 * PIPE_LATENCY) @(negedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Receiver: stretches of steady, random, mostly-ready and mostly-stalled
    initial
    begin : receiver
        int style;
        int len;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            style = $urandom_range(0, 3);
            len = $urandom_range(8, 80);
            repeat (len)
            begin
                @(negedge clk);
                case (style)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 9) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Compare each accepted result with the oldest expected pixel
    always @(posedge clk)
    begin : check_out
        logic [23:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pixel_expect.size() == 0)
                report_mismatch("unexpected item", m_axis_tdata, 0);
            else
            begin
                want = pixel_expect.pop_front();
                if (m_axis_tdata[7:0] !== want[7:0])
                    report_mismatch("out_blue", m_axis_tdata[7:0], want[7:0]);
                if (m_axis_tdata[15:8] !== want[15:8])
                    report_mismatch("out_green", m_axis_tdata[15:8], want[15:8]);
                if (m_axis_tdata[23:16] !== want[23:16])
                    report_mismatch("out_red", m_axis_tdata[23:16], want[23:16]);
            end
        end
    end

    // Stop a hung run
    initial
    begin : watchdog
        #(RUN_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

endmodule
